// ===== hdl/linear_resampler_to_stereo_defines.svh =====
// Assertion macros for the linear resampler checker.
// No dependencies; included by the checker file only.
`ifndef LINEAR_RESAMPLER_TO_STEREO_DEFINES_SVH
`define LINEAR_RESAMPLER_TO_STEREO_DEFINES_SVH

// Concurrent check, ignored while reset is high.
`define LRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs across reset.
`define LRS_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lrs_pkg.sv =====
// Shared constants and types for the linear resampler.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lrs_pkg;

  localparam int OUTPUT_RATE  = 48000;
  localparam int SAMPLE_WIDTH = 16;
  localparam int RATE_WIDTH   = 18;
  localparam int RATE_MIN     = 8000;
  localparam int MAX_RESULTS  = 12;
  localparam int COUNT_WIDTH  = $clog2(MAX_RESULTS + 1);

  // frame history per lane, power of two
  localparam int HIST_DEPTH = 8;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  localparam int PHASE_WIDTH = 21;
  localparam int REM_WIDTH   = $clog2(OUTPUT_RATE);

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // issue to lane result, in cycles
  localparam int LANE_LATENCY = 4;

  // OUTPUT_RATE = 2^DIV_SHIFT * DIV_ODD; the odd part is done by reciprocal
  localparam int DIV_SHIFT   = 7;
  localparam int DIV_ODD     = 375;
  localparam int RECIP_SHIFT = 34;
  localparam int RECIP_WIDTH = 26;
  localparam logic [RECIP_WIDTH-1:0] RECIP = 26'd45812985;  // ceil(2^34 / 375)

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [HIST_AW-1:0]             hist_addr_t;
  typedef logic signed [PHASE_WIDTH-1:0]  phase_t;
  typedef logic [REM_WIDTH-1:0]           rem_t;
  typedef logic [RATE_WIDTH-1:0]          rate_t;

  typedef enum logic [0:0] {
    REG_INPUT_RATE = 1'b0,
    REG_MONO_INPUT = 1'b1
  } reg_index_t;

  // one interpolation request from the sequencer to the lanes and merge stage
  typedef struct packed {
    logic       valid;
    hist_addr_t addr0;
    hist_addr_t addr1;
    rem_t       rem;
    logic       last_of_run;
    logic       buffer_end;
  } issue_t;

endpackage

// ===== hdl/linear_resampler_to_stereo.sv =====
// linear_resampler_to_stereo: top level; uses lrs_pkg, lrs_seq, lrs_lane, lrs_merge.
// The first result of a frame passes the sequencer, the lane stages and the merge queue.
// Throughput: a new frame is taken only once the results of the last one are issued;
// the sequencer issues one interpolation per cycle, limited by the 8-entry output queue.
// Reset (rst, synchronous): queue and phase cleared, input_rate = 48000, stereo mode.
`timescale 1ns / 1ps

module linear_resampler_to_stereo (
  input  logic                   clk,
  input  logic                   rst,
  // register write port
  input  logic                   wr_en,
  input  logic [0:0]             wr_index,
  input  lrs_pkg::rate_t         wr_data,
  // input frames
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lrs_pkg::sample_t       left_sample,
  input  lrs_pkg::sample_t       right_sample,
  input  logic                   last_of_buffer,
  // output frames at 48 kHz
  output logic                   out_valid,
  input  logic                   out_stall,
  output lrs_pkg::sample_t       out_left,
  output lrs_pkg::sample_t       out_right,
  output logic                   last_of_run,
  output logic                   buffer_end
);

  // Configuration. The user must make writes only while the block is idle; the
  // block does not enforce it. The sequencer samples the rate once per frame transfer.
  lrs_pkg::rate_t   input_rate;
  logic             mono_input;

  // Sequencer to lanes: history write and the per-result request.
  logic                hist_wr_en;
  lrs_pkg::hist_addr_t hist_wr_addr;
  lrs_pkg::issue_t     issue;
  logic                credit;

  // Lane results, registered in the last lane stage.
  lrs_pkg::sample_t left_res, right_res;
  lrs_pkg::sample_t right_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_rate <= lrs_pkg::RATE_WIDTH'(lrs_pkg::OUTPUT_RATE);
      mono_input <= 1'b0;
    end else if (wr_en) begin
      case (lrs_pkg::reg_index_t'(wr_index))
        lrs_pkg::REG_INPUT_RATE: input_rate <= wr_data;
        lrs_pkg::REG_MONO_INPUT: mono_input <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Mono: left sample feeds both lanes, right input is ignored.
  assign right_in = mono_input ? left_sample : right_sample;

  // Phase tracking. Each frame but the first of a buffer moves the phase back by
  // 48000; each result moves it forward by the clamped input rate. Results of a
  // frame are issued back to back, one per cycle, while queue slots are free.
  lrs_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .last_of_buffer (last_of_buffer),
    .input_rate     (input_rate),
    .credit         (credit),
    .wr_en          (hist_wr_en),
    .wr_addr        (hist_wr_addr),
    .issue          (issue)
  );

  // Two identical lanes, one per output channel. Each holds the last eight
  // frames of its channel in a circular buffer and runs the interpolation:
  // read, slope multiply, reciprocal divide by 48000, truncate and clamp.
  lrs_lane u_lane_left (
    .clk       (clk),
    .wr_en     (hist_wr_en),
    .wr_addr   (hist_wr_addr),
    .wr_sample (left_sample),
    .issue     (issue),
    .result    (left_res)
  );

  lrs_lane u_lane_right (
    .clk       (clk),
    .wr_en     (hist_wr_en),
    .wr_addr   (hist_wr_addr),
    .wr_sample (right_in),
    .issue     (issue),
    .result    (right_res)
  );

  // Merge: pairs the lane outputs with their run and buffer flags and
  // queues them for the output channel; a stalled output never blocks
  // frame intake until the queue is spoken for.
  lrs_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .left_res    (left_res),
    .right_res   (right_res),
    .credit      (credit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_left    (out_left),
    .out_right   (out_right),
    .last_of_run (last_of_run),
    .buffer_end  (buffer_end)
  );

endmodule

// ===== hdl/lrs_lane.sv =====
// One channel lane: frame history memory and four-stage interpolator.
// Depends on lrs_pkg.
`timescale 1ns / 1ps

module lrs_lane (
  input  logic             clk,
  input  logic             wr_en,
  input  lrs_pkg::hist_addr_t wr_addr,
  input  lrs_pkg::sample_t wr_sample,
  input  lrs_pkg::issue_t  issue,
  output lrs_pkg::sample_t result
);

  localparam int DIFF_W = lrs_pkg::SAMPLE_WIDTH + 1;
  localparam int PROD_W = DIFF_W + lrs_pkg::REM_WIDTH + 1;
  localparam int MAG_W  = lrs_pkg::SAMPLE_WIDTH + lrs_pkg::REM_WIDTH;
  localparam int A_W    = MAG_W - lrs_pkg::DIV_SHIFT;
  localparam int QP_W   = A_W + lrs_pkg::RECIP_WIDTH;
  localparam int Q_W    = QP_W - lrs_pkg::RECIP_SHIFT;
  localparam int ODD_W  = $clog2(lrs_pkg::DIV_ODD + 1);
  localparam int BACK_W = Q_W + ODD_W;
  localparam int SUM_W  = lrs_pkg::SAMPLE_WIDTH + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (lrs_pkg::SAMPLE_WIDTH - 1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  lrs_pkg::sample_t hist [lrs_pkg::HIST_DEPTH];

  // stage 1: history read
  lrs_pkg::sample_t s0_a, s1_a;
  lrs_pkg::rem_t    rem_a;
  // stage 2: slope times remainder
  lrs_pkg::sample_t          s0_b;
  logic signed [PROD_W-1:0]  prod_b;
  // stage 3: reciprocal multiply on the magnitude
  lrs_pkg::sample_t  s0_c;
  logic [QP_W-1:0]   recip_c;
  logic [A_W-1:0]    a_c;
  logic              low_nz_c;
  logic              neg_c;

  logic signed [DIFF_W-1:0]          diff_a;
  logic signed [lrs_pkg::REM_WIDTH:0] rem_s;
  logic [PROD_W-1:0]                 mag_full;
  logic [MAG_W-1:0]                  mag_b;
  logic [Q_W-1:0]                    q_c;
  logic [BACK_W-1:0]                 back_c;
  logic                              inexact;
  logic signed [SUM_W-1:0]           quo_s, floor_s, sum_s, res_s;
  lrs_pkg::sample_t                  sat_s;

  always_comb begin
    diff_a = DIFF_W'(s1_a) - DIFF_W'(s0_a);
    rem_s  = {1'b0, rem_a};
  end

  always_comb begin
    mag_full = prod_b[PROD_W-1] ? PROD_W'(-prod_b) : PROD_W'(prod_b);
    mag_b    = mag_full[MAG_W-1:0];
  end

  // floor(p / 48000) from the quotient of |p|, then truncate toward zero
  always_comb begin
    q_c     = recip_c[QP_W-1:lrs_pkg::RECIP_SHIFT];
    back_c  = BACK_W'(q_c) * BACK_W'(lrs_pkg::DIV_ODD);
    inexact = low_nz_c | (back_c != BACK_W'(a_c));
    quo_s   = SUM_W'(q_c);
    floor_s = neg_c ? -(quo_s + SUM_W'(inexact)) : quo_s;
    sum_s   = SUM_W'(s0_c) + floor_s;
    res_s   = sum_s[SUM_W-1] ? sum_s + SUM_W'(inexact) : sum_s;
    if (res_s > SAT_HI) begin
      sat_s = SAT_HI[lrs_pkg::SAMPLE_WIDTH-1:0];
    end else if (res_s < SAT_LO) begin
      sat_s = SAT_LO[lrs_pkg::SAMPLE_WIDTH-1:0];
    end else begin
      sat_s = res_s[lrs_pkg::SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[wr_addr] <= wr_sample;
    end
    s0_a     <= hist[issue.addr0];
    s1_a     <= hist[issue.addr1];
    rem_a    <= issue.rem;
    s0_b     <= s0_a;
    prod_b   <= PROD_W'(diff_a * rem_s);
    s0_c     <= s0_b;
    neg_c    <= prod_b[PROD_W-1];
    a_c      <= mag_b[MAG_W-1:lrs_pkg::DIV_SHIFT];
    low_nz_c <= |mag_b[lrs_pkg::DIV_SHIFT-1:0];
    recip_c  <= QP_W'(mag_b[MAG_W-1:lrs_pkg::DIV_SHIFT]) * QP_W'(lrs_pkg::RECIP);
    result   <= sat_s;
  end

endmodule

// ===== hdl/lrs_seq.sv =====
// Phase sequencer: takes frames, tracks output phase, issues interpolations.
// Depends on lrs_pkg.
`timescale 1ns / 1ps

module lrs_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                last_of_buffer,
  input  lrs_pkg::rate_t      input_rate,
  input  logic                credit,
  output logic                wr_en,
  output lrs_pkg::hist_addr_t wr_addr,
  output lrs_pkg::issue_t     issue
);

  typedef enum logic [0:0] {S_IDLE, S_RUN} state_t;

  localparam lrs_pkg::phase_t LIMIT = lrs_pkg::phase_t'(lrs_pkg::OUTPUT_RATE);
  localparam logic [lrs_pkg::COUNT_WIDTH-1:0] MAX_CNT =
    lrs_pkg::COUNT_WIDTH'(lrs_pkg::MAX_RESULTS);
  localparam logic [lrs_pkg::HIST_AW:0] O_MAX = (lrs_pkg::HIST_AW + 1)'(lrs_pkg::HIST_DEPTH - 1);

  state_t                           state;
  lrs_pkg::phase_t                  phase;
  logic                             have_prev;
  lrs_pkg::hist_addr_t              wp;
  logic [lrs_pkg::COUNT_WIDTH-1:0]  count;
  logic                             last_q;
  lrs_pkg::rate_t                   rate_q;

  lrs_pkg::rate_t                   rate_eff;
  lrs_pkg::phase_t                  rate_p, step1, step2, rem_wide;
  logic [lrs_pkg::COUNT_WIDTH-1:0]  count_p1;
  logic                             more_now, more_next, accept;
  logic [lrs_pkg::HIST_AW:0]        o_full;
  lrs_pkg::hist_addr_t              o0, o1;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign wr_en    = accept;
  assign wr_addr  = wp + 1'b1;

  always_comb begin
    if (input_rate == '0) begin
      rate_eff = lrs_pkg::RATE_WIDTH'(lrs_pkg::OUTPUT_RATE);
    end else if (input_rate < lrs_pkg::RATE_WIDTH'(lrs_pkg::RATE_MIN)) begin
      rate_eff = lrs_pkg::RATE_WIDTH'(lrs_pkg::RATE_MIN);
    end else begin
      rate_eff = input_rate;
    end
  end

  always_comb begin
    rate_p    = lrs_pkg::phase_t'(rate_q);
    step1     = phase + rate_p;
    step2     = step1 + rate_p;
    count_p1  = count + 1'b1;
    more_now  = (count < MAX_CNT) && (step1 <= LIMIT) && (last_q || phase < 0);
    more_next = (count_p1 < MAX_CNT) && (step2 <= LIMIT) && (last_q || step1 < 0);
  end

  // frames back from the newest: ceil(-phase / 48000) by threshold compares
  always_comb begin
    o_full = '0;
    for (int k = 0; k < lrs_pkg::HIST_DEPTH; k++) begin
      if (int'(phase) < -(k * lrs_pkg::OUTPUT_RATE)) begin
        o_full = o_full + 1'b1;
      end
    end
    o0       = (o_full > O_MAX) ? O_MAX[lrs_pkg::HIST_AW-1:0] : o_full[lrs_pkg::HIST_AW-1:0];
    o1       = (o0 != '0) ? o0 - 1'b1 : '0;
    rem_wide = phase + lrs_pkg::phase_t'(o_full) * lrs_pkg::phase_t'(lrs_pkg::OUTPUT_RATE);
  end

  always_comb begin
    issue.valid       = (state == S_RUN) && more_now && credit;
    issue.addr0       = wp - o0;
    issue.addr1       = wp - o1;
    issue.rem         = rem_wide[lrs_pkg::REM_WIDTH-1:0];
    issue.last_of_run = !more_next;
    issue.buffer_end  = !more_next && last_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      have_prev <= 1'b0;
      wp        <= '0;
      count     <= '0;
      last_q    <= 1'b0;
      rate_q    <= lrs_pkg::RATE_WIDTH'(lrs_pkg::OUTPUT_RATE);
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_q    <= last_of_buffer;
            rate_q    <= rate_eff;
            count     <= '0;
            phase     <= have_prev ? phase - LIMIT : '0;
            wp        <= wp + 1'b1;
            have_prev <= 1'b1;
            state     <= S_RUN;
          end
        end
        S_RUN: begin
          if (more_now) begin
            if (credit) begin
              count <= count_p1;
              phase <= step1;
              if (!more_next) begin
                state <= S_IDLE;
                if (last_q) begin
                  phase     <= '0;
                  have_prev <= 1'b0;
                end
              end
            end
          end else begin
            state <= S_IDLE;
            if (last_q) begin
              phase     <= '0;
              have_prev <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/lrs_merge.sv =====
// Merge stage: aligns both lane results with their flags, queues them, and
// drives the output channel. Depends on lrs_pkg.
`timescale 1ns / 1ps

module lrs_merge (
  input  logic             clk,
  input  logic             rst,
  input  lrs_pkg::issue_t  issue,
  input  lrs_pkg::sample_t left_res,
  input  lrs_pkg::sample_t right_res,
  output logic             credit,
  output logic             out_valid,
  input  logic             out_stall,
  output lrs_pkg::sample_t out_left,
  output lrs_pkg::sample_t out_right,
  output logic             last_of_run,
  output logic             buffer_end
);

  typedef struct packed {
    lrs_pkg::sample_t left;
    lrs_pkg::sample_t right;
    logic             last_of_run;
    logic             buffer_end;
  } entry_t;

  logic [lrs_pkg::LANE_LATENCY-1:0] pipe_valid, pipe_lor, pipe_be;
  entry_t                           fifo [lrs_pkg::FIFO_DEPTH];
  logic [lrs_pkg::FIFO_AW-1:0]      wr_ptr, rd_ptr;
  logic [lrs_pkg::FIFO_CW-1:0]      count, reserved;
  logic                             push, pop;
  entry_t                           head;

  localparam logic [lrs_pkg::FIFO_AW-1:0] PTR_LAST = lrs_pkg::FIFO_AW'(lrs_pkg::FIFO_DEPTH - 1);

  assign push      = pipe_valid[lrs_pkg::LANE_LATENCY-1];
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  // slots are reserved at issue so the queue never overflows
  assign credit    = (reserved < lrs_pkg::FIFO_CW'(lrs_pkg::FIFO_DEPTH));

  assign head        = fifo[rd_ptr];
  assign out_left    = head.left;
  assign out_right   = head.right;
  assign last_of_run = head.last_of_run;
  assign buffer_end  = head.buffer_end;

  always_ff @(posedge clk) begin
    pipe_lor <= {pipe_lor[lrs_pkg::LANE_LATENCY-2:0], issue.last_of_run};
    pipe_be  <= {pipe_be[lrs_pkg::LANE_LATENCY-2:0], issue.buffer_end};
    if (push) begin
      fifo[wr_ptr] <= '{left:        left_res,
                        right:       right_res,
                        last_of_run: pipe_lor[lrs_pkg::LANE_LATENCY-1],
                        buffer_end:  pipe_be[lrs_pkg::LANE_LATENCY-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      reserved   <= '0;
    end else begin
      pipe_valid <= {pipe_valid[lrs_pkg::LANE_LATENCY-2:0], issue.valid};
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      count    <= count + lrs_pkg::FIFO_CW'(push) - lrs_pkg::FIFO_CW'(pop);
      reserved <= reserved + lrs_pkg::FIFO_CW'(issue.valid) - lrs_pkg::FIFO_CW'(pop);
    end
  end

endmodule

// ===== hdl/lrs_checker.sv =====
// Port-level checks for linear_resampler_to_stereo, attached by bind.
// Depends on lrs_pkg and linear_resampler_to_stereo_defines.svh.
`timescale 1ns / 1ps
`include "linear_resampler_to_stereo_defines.svh"

module lrs_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input lrs_pkg::sample_t out_left,
  input lrs_pkg::sample_t out_right,
  input logic             last_of_run,
  input logic             buffer_end
);

  // buffer end is always the final result of its run
  `LRS_ASSERT(a_end_closes_run, clk, rst, out_valid && buffer_end |-> last_of_run, "buffer_end without last_of_run")

  // a frame transfer puts the block into its busy state, with in_stall high
  `LRS_ASSERT(a_busy_after_accept, clk, rst, in_valid && !in_stall |=> in_stall, "frame taken while still busy")

  `LRS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_left) && $stable(out_right) && $stable(last_of_run) && $stable(buffer_end), "stalled output changed")

  // reset empties the output queue and frees the input
  `LRS_ASSERT_NORST(a_reset_clears, clk, rst |=> !out_valid && !in_stall, "state not cleared by reset")

endmodule

bind linear_resampler_to_stereo lrs_checker u_lrs_checker (.*);

// ===== tb/sv/lrs_stereo_checker.sv =====
`timescale 1ns / 1ps
// Watches the register port and both frame channels of the resampler, predicts
// every 48 kHz stereo frame and compares it on transfer. Depends on lrs_pkg only.

module lrs_stereo_checker
  import lrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  rate_t       wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  sample_t     left_sample,
  input  sample_t     right_sample,
  input  logic        last_of_buffer,
  input  logic        out_valid,
  input  logic        out_stall,
  input  sample_t     out_left,
  input  sample_t     out_right,
  input  logic        last_of_run,
  input  logic        buffer_end,
  output int          errors,
  output int          pending
);

  localparam rate_t RATE_AT_RESET = 18'd48000;

  typedef struct packed {
    sample_t left_smp;
    sample_t right_smp;
    logic    run_end;
    logic    buf_end;
  } stereo_frame_t;

  stereo_frame_t stereo_due[$];
  stereo_frame_t got, want;

  rate_t   rate_cfg;
  logic    mono_cfg;
  sample_t hist_left  [HIST_DEPTH];
  sample_t hist_right [HIST_DEPTH];
  longint  phase_pos;    // next output position vs. newest frame, 1/OUTPUT_RATE units
  bit      frame_seen;   // current buffer has a frame
  int      err_count = 0;
  int      slot;

  function automatic sample_t lerp_sample(sample_t s0, sample_t s1, longint rem);
    longint num, v, hi, lo;
    hi  = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    lo  = -hi - 1;
    num = longint'(s0) * OUTPUT_RATE + (longint'(s1) - longint'(s0)) * rem;
    v   = num / OUTPUT_RATE;   // truncates toward zero
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return sample_t'(v);
  endfunction

  function automatic void resample_frame(sample_t l_in, sample_t r_in, logic closes);
    stereo_frame_t batch [MAX_RESULTS];
    longint rate, d, q, rem;
    int     n, j, o0, o1;
    bit     done;
    rate = longint'(rate_cfg);
    if (rate == 0) rate = OUTPUT_RATE;
    else if (rate < RATE_MIN) rate = RATE_MIN;

    if (frame_seen) begin
      phase_pos -= OUTPUT_RATE;
      for (j = HIST_DEPTH - 1; j > 0; j--) begin
        hist_left[j]  = hist_left[j - 1];
        hist_right[j] = hist_right[j - 1];
      end
    end else begin
      phase_pos = 0;
    end
    hist_left[0]  = l_in;
    hist_right[0] = mono_cfg ? l_in : r_in;
    frame_seen    = 1'b1;

    n    = 0;
    done = 1'b0;
    while (n < MAX_RESULTS && !done) begin
      d = phase_pos;
      // past the buffer end, or upper neighbor not here yet
      if (d + rate > OUTPUT_RATE || (!closes && d >= 0)) begin
        done = 1'b1;
      end else begin
        q = d / OUTPUT_RATE;
        if (q * OUTPUT_RATE > d) q -= 1;
        rem = d - q * OUTPUT_RATE;
        o0  = (-q > HIST_DEPTH - 1) ? HIST_DEPTH - 1 : int'(-q);
        o1  = (o0 > 0) ? o0 - 1 : 0;
        batch[n] = '{lerp_sample(hist_left[o0], hist_left[o1], rem),
                     lerp_sample(hist_right[o0], hist_right[o1], rem), 1'b0, 1'b0};
        phase_pos = d + rate;
        n++;
      end
    end

    if (n > 0) begin
      batch[n - 1].run_end = 1'b1;
      batch[n - 1].buf_end = closes;
    end
    for (j = 0; j < n; j++) stereo_due.push_back(batch[j]);
    if (closes) begin
      phase_pos  = 0;
      frame_seen = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rate_cfg   = RATE_AT_RESET;
      mono_cfg   = 1'b0;
      phase_pos  = 0;
      frame_seen = 1'b0;
      for (slot = 0; slot < HIST_DEPTH; slot++) begin
        hist_left[slot]  = '0;
        hist_right[slot] = '0;
      end
      stereo_due.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_INPUT_RATE: rate_cfg = wr_data;
          REG_MONO_INPUT: mono_cfg = wr_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_left, out_right, last_of_run, buffer_end};
        if (stereo_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected frame, expected none, got L=%0d R=%0d run=%0b end=%0b",
                   $time, got.left_smp, got.right_smp, got.run_end, got.buf_end);
        end else begin
          want = stereo_due.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: expected L=%0d R=%0d run=%0b end=%0b, got L=%0d R=%0d run=%0b end=%0b",
                     $time, want.left_smp, want.right_smp, want.run_end, want.buf_end,
                     got.left_smp, got.right_smp, got.run_end, got.buf_end);
          end
        end
      end
      if (in_valid && !in_stall) resample_frame(left_sample, right_sample, last_of_buffer);
    end
    errors  <= err_count;
    pending <= stereo_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the resampler bench: clock, reset, register writes and frame stimulus.
// Depends on lrs_pkg, linear_resampler_to_stereo and lrs_stereo_checker.

module testbench;
  import lrs_pkg::*;

  localparam int      RANDOM_ITEMS  = 280;
  localparam int      PHASE_ITEMS   = 40;
  localparam int      SETTLE_CYCLES = 16;    // well past the frame latency
  localparam int      IDLE_PCT      = 26;
  localparam int      HOLD_CYCLES   = 400;
  localparam longint  TIMEOUT_NS    = 5_000_000;
  localparam sample_t SMP_MAX       = 16'sh7fff;
  localparam sample_t SMP_MIN       = 16'sh8000;

  logic       clk;
  logic       rst;
  logic       wr_en;
  logic [0:0] wr_index;
  rate_t      wr_data;
  logic       in_valid;
  logic       in_stall;
  sample_t    left_sample;
  sample_t    right_sample;
  logic       last_of_buffer;
  logic       out_valid;
  logic       out_stall;
  sample_t    out_left;
  sample_t    out_right;
  logic       last_of_run;
  logic       buffer_end;

  logic       no_idle;    // both sides run flat out while set
  logic       hold_req;   // asks the receiver for one long hold-off
  int         mismatch_count;
  int         results_due;

  linear_resampler_to_stereo u_dut (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .last_of_buffer (last_of_buffer),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left       (out_left),
    .out_right      (out_right),
    .last_of_run    (last_of_run),
    .buffer_end     (buffer_end)
  );

  lrs_stereo_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .last_of_buffer (last_of_buffer),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left       (out_left),
    .out_right      (out_right),
    .last_of_run    (last_of_run),
    .buffer_end     (buffer_end),
    .errors         (mismatch_count),
    .pending        (results_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Output side. Random stall about a quarter of the time; on request one long
  // hold-off, counted here, so the output queue fills and the block stalls its input.
  initial begin : receiver
    int hold_cnt;
    bit hold_done;
    hold_cnt  = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_cnt++;
        if (hold_cnt == HOLD_CYCLES) begin
          hold_done = 1'b1;
        end
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Random sample: extremes, full-range noise, or a small step from the last one
  // so neighboring frames also interpolate over short distances.
  function automatic sample_t next_sample(sample_t prev);
    int v;
    case ($urandom_range(9))
      0:       v = int'(SMP_MAX);
      1:       v = int'(SMP_MIN);
      2, 3, 4: v = int'(sample_t'($urandom));
      default: v = int'(prev) + int'($urandom_range(600)) - 300;
    endcase
    if (v > int'(SMP_MAX)) v = int'(SMP_MAX);
    if (v < int'(SMP_MIN)) v = int'(SMP_MIN);
    return sample_t'(v);
  endfunction

  // One input transfer, preceded by random idle cycles. Valid and payload hold
  // steady while the block stalls.
  task automatic send_frame(sample_t l, sample_t r, logic closes);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    left_sample    <= l;
    right_sample   <= r;
    last_of_buffer <= closes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Both registers, back to back; wr_en stays high across the two writes.
  task automatic write_regs(rate_t rate, logic mono);
    wr_en    <= 1'b1;
    wr_index <= REG_INPUT_RATE;
    wr_data  <= rate;
    @(posedge clk);
    wr_index <= REG_MONO_INPUT;
    wr_data  <= rate_t'(mono);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // Sender pauses until every predicted frame has been transferred, then gives
  // frames that yield no output time to leave the pipeline.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random phase: new settings, then buffers of random length. A buffer
  // cut off by the phase end stays open, so the next setting applies mid-buffer.
  task automatic run_phase(int p);
    rate_t   rate;
    logic    mono;
    sample_t l, r;
    int      sent, blen, k;
    logic    closes;
    case (p)
      0: rate = 18'd192000;
      1: rate = 18'd8000;
      2: rate = 18'd48000;
      3: rate = 18'd262143;
      default: begin
        case ($urandom_range(7))
          0:       rate = '0;
          1:       rate = rate_t'($urandom_range(7999, 1));
          2:       rate = 18'd44100;
          3:       rate = 18'd96000;
          4:       rate = 18'd262143;
          default: rate = rate_t'($urandom_range(192000, 8000));
        endcase
      end
    endcase
    mono = (p < 2) ? p[0] : 1'($urandom_range(1));

    drain_and_settle();
    write_regs(rate, mono);
    no_idle <= (p == 2);
    // lowest rate gives six frames per input, so the hold-off backs up fast
    if (p == 1) hold_req <= 1'b1;

    l    = '0;
    r    = '0;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      blen = ($urandom_range(9) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 1);
      for (k = 0; k < blen && sent < PHASE_ITEMS; k++) begin
        l = next_sample(l);
        r = next_sample(r);
        // now and then a buffer is closed early
        closes = (k == blen - 1) || ($urandom_range(19) == 0);
        send_frame(l, r, closes);
        sent++;
        if (closes) k = blen;
      end
    end
  endtask

  initial begin : stimulus
    int k;
    int p;
    rst            <= 1'b1;
    wr_en          <= 1'b0;
    wr_index       <= REG_INPUT_RATE;
    wr_data        <= '0;
    in_valid       <= 1'b0;
    left_sample    <= '0;
    right_sample   <= '0;
    last_of_buffer <= 1'b0;
    no_idle        <= 1'b0;
    hold_req       <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // unity rate, stereo, full-scale swings between frames
    write_regs(18'd48000, 1'b0);
    send_frame(SMP_MAX, SMP_MIN, 1'b0);
    send_frame(SMP_MIN, SMP_MAX, 1'b0);
    send_frame(16'sd0, -16'sd1, 1'b0);
    send_frame(SMP_MAX, SMP_MAX, 1'b1);

    // lowest rate, mono: the closing frame fills every result slot of a transfer
    drain_and_settle();
    write_regs(18'd8000, 1'b1);
    send_frame(SMP_MAX, 16'sd1234, 1'b0);
    send_frame(SMP_MIN, SMP_MAX, 1'b1);

    // one-frame buffer at double rate yields no output and no buffer_end
    drain_and_settle();
    write_regs(18'd96000, 1'b0);
    send_frame(16'sd100, -16'sd100, 1'b1);

    // top of the rate field: frames pile up with no output yet
    drain_and_settle();
    write_regs(18'd262143, 1'b0);
    for (k = 0; k < 5; k++) begin
      send_frame(k[0] ? SMP_MIN : SMP_MAX, k[0] ? SMP_MAX : SMP_MIN, 1'b0);
    end

    // same buffer goes on at the lowest rate: backlog exceeds one transfer's
    // results and spills into the following frames, the rest cut at buffer end
    drain_and_settle();
    write_regs(18'd8000, 1'b0);
    send_frame(16'sd2000, -16'sd2000, 1'b0);
    send_frame(-16'sd1, 16'sd1, 1'b0);
    send_frame(SMP_MIN, SMP_MAX, 1'b1);

    // zero rate falls back to 48 kHz
    drain_and_settle();
    write_regs('0, 1'b1);
    send_frame(16'sd300, 16'sd7, 1'b0);
    send_frame(-16'sd300, 16'sd7, 1'b0);
    send_frame(SMP_MAX, 16'sd7, 1'b1);

    // rates below the range saturate to 8 kHz
    drain_and_settle();
    write_regs(18'd1, 1'b1);
    send_frame(SMP_MIN, 16'sd0, 1'b0);
    send_frame(SMP_MAX, 16'sd0, 1'b1);
    drain_and_settle();
    write_regs(18'd7999, 1'b0);
    send_frame(16'sd12345, -16'sd12345, 1'b1);

    // top of the nominal range: four frames make one output
    drain_and_settle();
    write_regs(18'd192000, 1'b0);
    send_frame(SMP_MAX, SMP_MIN, 1'b0);
    send_frame(16'sd0, 16'sd0, 1'b0);
    send_frame(SMP_MIN, SMP_MAX, 1'b0);
    send_frame(-16'sd1, 16'sd1, 1'b1);

    for (p = 0; p * PHASE_ITEMS < RANDOM_ITEMS; p++) run_phase(p);

    drain_and_settle();
    if (mismatch_count == 0 && results_due == 0) begin
      $display("linear_resampler_to_stereo verification clean");
    end else begin
      $display("linear_resampler_to_stereo verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("linear_resampler_to_stereo verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lrs_pkg.sv
hdl/lrs_lane.sv
hdl/lrs_seq.sv
hdl/lrs_merge.sv
hdl/linear_resampler_to_stereo.sv
hdl/lrs_checker.sv
tb/sv/lrs_stereo_checker.sv
tb/sv/testbench.sv
